### sv/msbpm_pkg.sv
`timescale 1ns / 1ps

package msbpm_pkg;

    // Input request: one structure column
    typedef struct packed {
        logic [7:0] symbol;
        logic [3:0] helix_id;
        logic       last;
    } t_in_req;

    // Per-column event codes
    typedef enum logic [2:0] {
        ST_NEUTRAL   = 3'd0,
        ST_OPENED    = 3'd1,
        ST_PAIRED    = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_MISMATCH  = 3'd4,
        ST_OVERFLOW  = 3'd5,
        ST_IGNORED   = 3'd6
    } t_status;

    // Result request
    typedef struct packed {
        t_status     status;
        logic [15:0] position;
        logic [15:0] partner_pos;
        logic [3:0]  pair_kind;
        logic [3:0]  pair_helix;
        logic [7:0]  opener_char;
        logic        unclosed;
        logic [3:0]  unclosed_helix;
        logic [15:0] unclosed_pos;
        logic [7:0]  unclosed_char;
    } t_out_req;

    // Symbol class decided by the front end
    typedef enum logic [1:0] {
        CLS_NEUTRAL,
        CLS_OPEN,
        CLS_BCLOSE,
        CLS_LCLOSE
    } t_cls;

    // Classified column handed from front to back through the queue
    typedef struct packed {
        t_cls        cls;
        logic [7:0]  symbol;
        logic [3:0]  kind;
        logic [3:0]  helix_id;
        logic        last;
        logic [15:0] position;
    } t_work;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BS_FETCH,
        BS_DEPTH,
        BS_EXEC,
        BS_SCAN,
        BS_UDEP,
        BS_UTOP,
        BS_EMIT
    } t_bstate;

    // Structure characters
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_LANGLE  = 8'h3C;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_RANGLE  = 8'h3E;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_J = 8'h6A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_J = 8'h4A;
    localparam logic [7:0] CH_CASE_OFS = 8'h20;

endpackage

### sv/msbpm_ram.sv
`timescale 1ns / 1ps

module msbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/msbpm_front.sv
`timescale 1ns / 1ps

module msbpm_front #(
    parameter int MAX_COLUMNS = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  msbpm_pkg::t_in_req i_in,
    input  logic               i_q_full,
    output logic               o_push,
    output msbpm_pkg::t_work   o_push_data
);

    localparam int CW = $clog2(MAX_COLUMNS);

    logic [CW-1:0]    r_col;
    logic [CW-1:0]    n_col;
    logic [CW+15:0]   c_colx;
    logic [7:0]       c_ofs;
    logic             c_accept;
    msbpm_pkg::t_work c_work;

    assign o_in_stall = i_q_full;
    assign c_accept   = i_in_valid && !i_q_full;
    assign o_push     = c_accept;
    assign o_push_data = c_work;

    // Classify the symbol and tag it with its column
    assign c_colx = {16'b0, r_col};
    assign c_ofs  = i_in.symbol - msbpm_pkg::CH_UPPER_A;

    always_comb begin
        c_work.symbol   = i_in.symbol;
        c_work.helix_id = i_in.helix_id;
        c_work.last     = i_in.last;
        c_work.position = c_colx[15:0];
        c_work.kind     = c_ofs[3:0] + 4'd1;
        case (i_in.symbol) inside
            msbpm_pkg::CH_LBRACE, msbpm_pkg::CH_LBRACK, msbpm_pkg::CH_LANGLE,
            msbpm_pkg::CH_LPAREN, msbpm_pkg::CH_HASH, msbpm_pkg::CH_STAR,
            [msbpm_pkg::CH_LOWER_A:msbpm_pkg::CH_LOWER_J]: begin
                c_work.cls = msbpm_pkg::CLS_OPEN;
            end
            msbpm_pkg::CH_RBRACE, msbpm_pkg::CH_RBRACK, msbpm_pkg::CH_RANGLE,
            msbpm_pkg::CH_RPAREN: begin
                c_work.cls = msbpm_pkg::CLS_BCLOSE;
            end
            [msbpm_pkg::CH_UPPER_A:msbpm_pkg::CH_UPPER_J]: begin
                c_work.cls = msbpm_pkg::CLS_LCLOSE;
            end
            default: begin
                c_work.cls = msbpm_pkg::CLS_NEUTRAL;
            end
        endcase
    end

    // Advance the column counter, wrap at the column limit, restart on last
    always_comb begin
        n_col = r_col;
        if (c_accept) begin
            if (i_in.last || r_col == CW'(MAX_COLUMNS - 1)) begin
                n_col = '0;
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

endmodule

### sv/msbpm_queue.sv
`timescale 1ns / 1ps

module msbpm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  msbpm_pkg::t_work i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output msbpm_pkg::t_work o_head
);

    msbpm_pkg::t_work r_slot [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_slot[r_rptr];

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### sv/msbpm_back.sv
`timescale 1ns / 1ps

module msbpm_back #(
    parameter int HELIX_IDS   = 16,
    parameter int STACK_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  msbpm_pkg::t_work    i_q_head,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output msbpm_pkg::t_out_req o_out
);

    localparam int HW = (HELIX_IDS > 1) ? $clog2(HELIX_IDS) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int SN = HELIX_IDS * STACK_DEPTH;
    localparam int AW = (SN > 1) ? $clog2(SN) : 1;
    localparam int EW = 24;

    msbpm_pkg::t_bstate  r_state;
    msbpm_pkg::t_bstate  n_state;
    msbpm_pkg::t_work    r_cur;
    logic [HW-1:0]       r_h;
    logic [AW-1:0]       r_base;
    logic [DW-1:0]       r_depth;
    logic                r_err;
    logic [HELIX_IDS-1:0] r_dvalid;
    logic [HELIX_IDS-1:0] r_nonempty;
    logic [HW-1:0]       r_k;
    logic [AW-1:0]       r_kbase;
    msbpm_pkg::t_out_req r_res;
    msbpm_pkg::t_out_req r_out;
    logic                r_out_valid;

    // Memory ports
    logic          dep_we;
    logic [DW-1:0] dep_wdata;
    logic          dep_re;
    logic [HW-1:0] dep_raddr;
    logic [DW-1:0] dep_rdata;
    logic          stk_we;
    logic [AW-1:0] stk_waddr;
    logic [EW-1:0] stk_wdata;
    logic          stk_re;
    logic [AW-1:0] stk_raddr;
    logic [EW-1:0] stk_rdata;

    // Combinational datapath
    logic [HW-1:0]       c_h;
    logic [AW-1:0]       c_base;
    logic [DW-1:0]       c_d;
    logic [AW:0]         c_top_sum;
    logic [AW:0]         c_utop_sum;
    logic                c_out_free;
    msbpm_pkg::t_out_req c_res;
    logic                c_push;
    logic                c_pop;
    logic                c_err_set;
    logic                c_err_next;
    logic [DW-1:0]       c_new_depth;
    logic [HW+3:0]       c_kx;

    // Sequencer controls
    logic c_take;
    logic c_cap_depth;
    logic c_exec_go;
    logic c_load_out;
    logic c_out_from_res;
    logic c_store_res;
    logic c_scan_start;
    logic c_scan_step;
    logic c_cap_unc;
    logic c_clear;

    assign c_out_free = !r_out_valid || !i_out_stall;

    // Map the helix index onto the stacks that exist
    always_comb begin
        c_h = '0;
        for (int j = 0; j < 16; j++) begin
            if (i_q_head.helix_id == 4'(j)) begin
                c_h = HW'(j % HELIX_IDS);
            end
        end
    end
    assign c_base = AW'(c_h) * AW'(STACK_DEPTH);

    // Depth of the addressed stack; an unwritten count reads as empty
    assign c_d        = r_dvalid[r_h] ? dep_rdata : '0;
    assign c_top_sum  = {1'b0, r_base} + (AW+1)'(c_d) - (AW+1)'(1);
    assign c_utop_sum = {1'b0, r_kbase} + (AW+1)'(dep_rdata) - (AW+1)'(1);
    assign c_kx       = {4'b0, r_k};

    // Carry out one column against its stack
    always_comb begin
        c_res             = '0;
        c_res.status      = msbpm_pkg::ST_NEUTRAL;
        c_res.position    = r_cur.position;
        c_res.pair_helix  = r_cur.helix_id;
        c_push            = 1'b0;
        c_pop             = 1'b0;
        c_err_set         = 1'b0;
        if (r_err) begin
            c_res.status = msbpm_pkg::ST_IGNORED;
        end else begin
            case (r_cur.cls)
                msbpm_pkg::CLS_OPEN: begin
                    if (r_depth == DW'(STACK_DEPTH)) begin
                        c_res.status = msbpm_pkg::ST_OVERFLOW;
                        c_err_set    = 1'b1;
                    end else begin
                        c_res.status = msbpm_pkg::ST_OPENED;
                        c_push       = 1'b1;
                    end
                end
                msbpm_pkg::CLS_BCLOSE, msbpm_pkg::CLS_LCLOSE: begin
                    if (r_depth == '0) begin
                        c_res.status = msbpm_pkg::ST_UNDERFLOW;
                        c_err_set    = 1'b1;
                    end else begin
                        c_res.partner_pos = stk_rdata[23:8];
                        c_res.opener_char = stk_rdata[7:0];
                        if (r_cur.cls == msbpm_pkg::CLS_LCLOSE &&
                            stk_rdata[7:0] != r_cur.symbol + msbpm_pkg::CH_CASE_OFS) begin
                            c_res.status = msbpm_pkg::ST_MISMATCH;
                            c_err_set    = 1'b1;
                        end else begin
                            c_res.status = msbpm_pkg::ST_PAIRED;
                            c_pop        = 1'b1;
                            if (r_cur.cls == msbpm_pkg::CLS_LCLOSE) begin
                                c_res.pair_kind = r_cur.kind;
                            end
                        end
                    end
                end
                default: begin
                    c_res.status = msbpm_pkg::ST_NEUTRAL;
                end
            endcase
        end
    end

    assign c_err_next  = r_err || c_err_set;
    assign c_new_depth = c_push ? (r_depth + DW'(1)) : (r_depth - DW'(1));
    assign dep_wdata   = c_new_depth;
    assign stk_waddr   = r_base + AW'(r_depth);
    assign stk_wdata   = {r_cur.position, r_cur.symbol};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            msbpm_pkg::BS_FETCH: begin
                if (!i_q_empty) begin
                    n_state = msbpm_pkg::BS_DEPTH;
                end
            end
            msbpm_pkg::BS_DEPTH: begin
                n_state = msbpm_pkg::BS_EXEC;
            end
            msbpm_pkg::BS_EXEC: begin
                if (r_cur.last) begin
                    n_state = c_err_next ? msbpm_pkg::BS_EMIT : msbpm_pkg::BS_SCAN;
                end else if (c_out_free) begin
                    n_state = msbpm_pkg::BS_FETCH;
                end
            end
            msbpm_pkg::BS_SCAN: begin
                if (r_nonempty[r_k]) begin
                    n_state = msbpm_pkg::BS_UDEP;
                end else if (r_k == HW'(HELIX_IDS - 1)) begin
                    n_state = msbpm_pkg::BS_EMIT;
                end
            end
            msbpm_pkg::BS_UDEP: begin
                n_state = msbpm_pkg::BS_UTOP;
            end
            msbpm_pkg::BS_UTOP: begin
                n_state = msbpm_pkg::BS_EMIT;
            end
            msbpm_pkg::BS_EMIT: begin
                if (c_out_free) begin
                    n_state = msbpm_pkg::BS_FETCH;
                end
            end
            default: begin
                n_state = msbpm_pkg::BS_FETCH;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        c_take         = 1'b0;
        c_cap_depth    = 1'b0;
        c_exec_go      = 1'b0;
        c_load_out     = 1'b0;
        c_out_from_res = 1'b0;
        c_store_res    = 1'b0;
        c_scan_start   = 1'b0;
        c_scan_step    = 1'b0;
        c_cap_unc      = 1'b0;
        c_clear        = 1'b0;
        dep_re         = 1'b0;
        dep_raddr      = c_h;
        stk_re         = 1'b0;
        stk_raddr      = c_top_sum[AW-1:0];
        case (r_state)
            msbpm_pkg::BS_FETCH: begin
                c_take = !i_q_empty;
                dep_re = !i_q_empty;
            end
            msbpm_pkg::BS_DEPTH: begin
                c_cap_depth = 1'b1;
                stk_re      = 1'b1;
            end
            msbpm_pkg::BS_EXEC: begin
                c_exec_go    = r_cur.last || c_out_free;
                c_load_out   = !r_cur.last && c_out_free;
                c_store_res  = r_cur.last;
                c_scan_start = r_cur.last;
            end
            msbpm_pkg::BS_SCAN: begin
                dep_raddr = r_k;
                if (r_nonempty[r_k]) begin
                    dep_re = 1'b1;
                end else begin
                    c_scan_step = (r_k != HW'(HELIX_IDS - 1));
                end
            end
            msbpm_pkg::BS_UDEP: begin
                stk_re    = 1'b1;
                stk_raddr = c_utop_sum[AW-1:0];
            end
            msbpm_pkg::BS_UTOP: begin
                c_cap_unc = 1'b1;
            end
            msbpm_pkg::BS_EMIT: begin
                c_load_out     = c_out_free;
                c_out_from_res = 1'b1;
                c_clear        = c_out_free;
            end
            default: begin
                c_take = 1'b0;
            end
        endcase
    end

    assign o_q_pop = c_take;
    assign dep_we  = c_exec_go && (c_push || c_pop);
    assign stk_we  = c_exec_go && c_push;

    // Per-helix stack depths
    msbpm_ram #(
        .WIDTH (DW),
        .DEPTH (HELIX_IDS)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (r_h),
        .i_wdata (dep_wdata),
        .i_re    (dep_re),
        .i_raddr (dep_raddr),
        .o_rdata (dep_rdata)
    );

    // Stack entries: open column and symbol
    msbpm_ram #(
        .WIDTH (EW),
        .DEPTH (SN)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // Hold the column under work and its scratch values
    always_ff @(posedge i_clk) begin
        if (c_take) begin
            r_cur  <= i_q_head;
            r_h    <= c_h;
            r_base <= c_base;
        end
        if (c_cap_depth) begin
            r_depth <= c_d;
        end
        if (c_store_res) begin
            r_res <= c_res;
        end
        if (c_cap_unc) begin
            r_res.unclosed       <= 1'b1;
            r_res.unclosed_helix <= c_kx[3:0];
            r_res.unclosed_pos   <= stk_rdata[23:8];
            r_res.unclosed_char  <= stk_rdata[7:0];
        end
        if (c_scan_start) begin
            r_kbase <= '0;
        end else if (c_scan_step) begin
            r_kbase <= r_kbase + AW'(STACK_DEPTH);
        end
        if (c_load_out) begin
            r_out <= c_out_from_res ? r_res : c_res;
        end
    end

    // Control state: sequencer, error latch, stack flags, scan index, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msbpm_pkg::BS_FETCH;
            r_err       <= 1'b0;
            r_dvalid    <= '0;
            r_nonempty  <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_clear) begin
                r_err      <= 1'b0;
                r_dvalid   <= '0;
                r_nonempty <= '0;
            end else if (c_exec_go) begin
                r_err <= c_err_next;
                if (c_push || c_pop) begin
                    r_dvalid[r_h]   <= 1'b1;
                    r_nonempty[r_h] <= (c_new_depth != '0);
                end
            end
            if (c_scan_start) begin
                r_k <= '0;
            end else if (c_scan_step) begin
                r_k <= r_k + HW'(1);
            end
            if (c_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### sv/multi_stack_bracket_pair_matcher_core.sv
`timescale 1ns / 1ps

// Bracket pair matcher with one bounded stack per helix index.
// Input channel: i_in_valid / o_in_stall carry one structure column per request
// (symbol, helix_id, last). Output channel: o_out_valid / i_out_stall carry one
// result request per column, in column order.
// A front end classifies each symbol and numbers the column; a two-entry queue
// decouples it from the back end, which reads the stack depth and the stack top
// from two RAMs and writes them back.
// Flow: an ordinary column passes three back-end steps (depth read, top read,
// update); the back end takes a new column only after it has finished the last
// one, while the queue accepts columns meanwhile. A column flagged last with no
// error pending or raised by it also scans the stacks, one helix index per cycle,
// and stops at the first stack still holding an opener; HELIX_IDS bounds the scan.
// When the receiver stalls, the output register holds its request, the back end
// waits, the queue fills and o_in_stall rises.
// Reset (i_rst_n low, synchronous) clears the column counter, the error latch,
// the queue and all stack depths; no clearing pass is needed. A last column also
// restarts the column counter and, after its result is issued, clears the error latch and all stack depths.
module multi_stack_bracket_pair_matcher_core #(
    parameter int HELIX_IDS   = 16,
    parameter int STACK_DEPTH = 256,
    parameter int MAX_COLUMNS = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  msbpm_pkg::t_in_req  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output msbpm_pkg::t_out_req o_out
);

    logic             q_push;
    msbpm_pkg::t_work q_push_data;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    msbpm_pkg::t_work q_head;

    // Classify and number columns
    msbpm_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // Decouple front and back
    msbpm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    // Run the stacks
    msbpm_back #(
        .HELIX_IDS   (HELIX_IDS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("queue reports full and empty together");

    a_kind_only_paired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.pair_kind != 4'd0) |->
            (o_out.status == msbpm_pkg::ST_PAIRED))
        else $error("pair kind set on a result that is not a pair");

    a_unclosed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.unclosed) |->
            (o_out.status != msbpm_pkg::ST_UNDERFLOW &&
             o_out.status != msbpm_pkg::ST_MISMATCH &&
             o_out.status != msbpm_pkg::ST_OVERFLOW &&
             o_out.status != msbpm_pkg::ST_IGNORED))
        else $error("leftover opener reported alongside an error");

    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == msbpm_pkg::ST_IGNORED) |->
            (o_out.partner_pos == 16'd0 && o_out.opener_char == 8'd0))
        else $error("ignored column carries partner data");
`endif

endmodule
